@@ rtl/core/looping_pin_pattern_generator_macros.svh @@
// Assertion helpers shared by the RTL of the pattern generator.
`ifndef LOOPING_PIN_PATTERN_GENERATOR_MACROS_SVH
`define LOOPING_PIN_PATTERN_GENERATOR_MACROS_SVH

// A clocked check that is switched off while reset is held.
`define LPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// A clocked check that also holds while reset is held.
`define LPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/lpg_pkg.sv @@
package lpg_pkg;

    // Field widths of the stream words and of the configuration register.
    localparam int OPCODE_W    = 2;
    localparam int SIDX_W      = 16;
    localparam int PIDX_W      = 4;
    localparam int PINS_W      = 8;
    localparam int POS_W       = 10;
    localparam int CFG_W       = 11;
    localparam int S_TDATA_W   = 24;
    localparam int RES_W       = PINS_W + 1 + POS_W + 1;
    localparam int M_TDATA_W   = 24;

    // Opcodes carried on the input tuser.
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TOGGLE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } t_state;

    // One result word; the first member sits in the highest bits.
    typedef struct packed {
        logic              accepted;
        logic [POS_W-1:0]  played_position;
        logic              pins_driven;
        logic [PINS_W-1:0] pin_values;
    } t_result;

endpackage

@@ rtl/core/lpg_store.sv @@
module lpg_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/looping_pin_pattern_generator.sv @@
// Each word reads the pattern store in the cycle it is accepted. In the next, in ST_EXEC,
// a valid toggle writes the store back and the result is loaded into the output register,
// or parked in a hold register while that one is full; input ready stays low until the
// word leaves ST_EXEC or ST_HOLD. One word can be accepted while the previous result
// waits; the word after it stalls. Reset is synchronous and active low; afterwards the
// store is swept to zero with s_axis_tready low, configuration writes accepted.
`include "looping_pin_pattern_generator_macros.svh"

module looping_pin_pattern_generator #(
    parameter int MAX_SAMPLES = 1024,
    parameter int PIN_COUNT   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_index [15:0], pin_index [19:16], zero [23:20]
    input  logic [lpg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  logic [lpg_pkg::OPCODE_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pin_values [7:0], pins_driven [8], played_position [18:9], accepted [19],
    // zero [23:20]
    output logic [lpg_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [lpg_pkg::CFG_W-1:0]      i_cfg_wr_data
);

    import lpg_pkg::*;

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int XW = ((CW > SIDX_W) ? CW : SIDX_W) + 1;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_sample_count;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_clr_addr;
    logic [OPCODE_W-1:0]   r_op;
    logic [AW-1:0]         r_addr;
    logic                  r_cnt_nz;
    logic                  r_tog_ok;
    logic [PIDX_W-1:0]     r_pidx;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               r_hold;

    logic                  w_accept;
    logic [SIDX_W-1:0]     w_sidx;
    logic [PIDX_W-1:0]     w_pidx;
    logic [XW-1:0]         w_count;
    logic [AW-1:0]         w_cur;
    logic                  w_tog_ok;
    logic [AW-1:0]         w_rd_addr;
    logic [PIN_COUNT-1:0]  w_rd_data;
    logic [PIN_COUNT-1:0]  w_mask;
    logic [XW-1:0]         w_next;
    t_result               w_res;
    logic                  w_out_free;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [PIN_COUNT-1:0]  w_mem_wdata;
    logic                  w_load_out;
    logic                  w_load_hold;
    logic                  w_clr_last;

    // Input word fields.
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_sidx   = s_axis_tdata[SIDX_W-1:0];
    assign w_pidx   = s_axis_tdata[SIDX_W+PIDX_W-1:SIDX_W];

    // Effective loop length, saturated to the store depth.
    assign w_count = (XW'(r_sample_count) > XW'(MAX_SAMPLES)) ? XW'(MAX_SAMPLES)
                                                                 : XW'(r_sample_count);

    // A play position left beyond a shortened loop restarts at zero.
    assign w_cur     = (XW'(r_pos) >= w_count) ? '0 : r_pos;
    assign w_tog_ok  = (XW'(w_sidx) < w_count) && (w_pidx < PIDX_W'(PIN_COUNT));
    assign w_rd_addr = (s_axis_tuser == OP_TICK) ? w_cur : w_sidx[AW-1:0];

    lpg_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW),
        .DW    (PIN_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (w_mem_wdata)
    );

    // Result and position update of the word being executed.
    assign w_mask = PIN_COUNT'(1) << r_pidx;
    assign w_next = XW'(r_addr) + XW'(1);

    always_comb begin
        w_res = '0;
        n_pos = r_pos;
        case (r_op)
            OP_TICK: begin
                w_res.accepted = 1'b1;
                if (r_cnt_nz) begin
                    w_res.pin_values      = PINS_W'(w_rd_data);
                    w_res.pins_driven     = 1'b1;
                    w_res.played_position = POS_W'(r_addr);
                    n_pos = (w_next >= w_count) ? '0 : AW'(w_next);
                end
            end
            OP_TOGGLE: begin
                w_res.accepted = r_tog_ok;
            end
            OP_RESTART: begin
                w_res.accepted = 1'b1;
                n_pos = '0;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_clr_last = (r_clr_addr == AW'(MAX_SAMPLES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = w_out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_waddr   = r_addr;
        w_mem_wdata   = w_rd_data ^ w_mask;
        w_load_out    = 1'b0;
        w_load_hold   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_EXEC: begin
                w_mem_we    = (r_op == OP_TOGGLE) && r_tog_ok;
                w_load_out  = w_out_free;
                w_load_hold = !w_out_free;
            end
            ST_HOLD: begin
                w_load_out = w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_sample_count <= '0;
            r_pos          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_wr_en) begin
                r_sample_count <= i_cfg_wr_data;
            end
            if (r_state == ST_EXEC) begin
                r_pos <= n_pos;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Word context captured at acceptance, and the result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= s_axis_tuser;
            r_addr   <= w_rd_addr;
            r_cnt_nz <= (w_count != '0);
            r_tog_ok <= w_tog_ok;
            r_pidx   <= w_pidx;
        end
        if (w_load_hold) begin
            r_hold <= w_res;
        end
        if (w_load_out) begin
            r_out <= (r_state == ST_HOLD) ? r_hold : w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

    `LPG_ASSERT(a_no_ready_in_clear, i_clk, i_rst_n, (r_state == ST_CLEAR) |-> !s_axis_tready, "input ready during clearing sweep")
    `LPG_ASSERT(a_accept_to_exec, i_clk, i_rst_n, w_accept |=> (r_state == ST_EXEC), "accepted word not executed next cycle")
    `LPG_ASSERT(a_write_only_toggle, i_clk, i_rst_n, (w_mem_we && (r_state != ST_CLEAR)) |-> (r_op == OP_TOGGLE), "store written by a word that is not a toggle")
    `LPG_ASSERT(a_hold_means_busy, i_clk, i_rst_n, (r_state == ST_HOLD) |-> r_out_valid, "result parked while the output register is empty")
    `LPG_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    localparam int MAX_SAMPLES = 1024;
    localparam int PIN_COUNT   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;
    localparam int PIN_IW      = $clog2(PINS_W);

    // The one opcode the block has no use for.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [OPCODE_W-1:0]    s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_wr_en;
    logic [CFG_W-1:0]       i_cfg_wr_data;

    // Our own copy of the pattern store, play position and sample count.
    logic [PINS_W-1:0]      pin_store [0:MAX_SAMPLES-1];
    logic [POS_W-1:0]       play_pos;
    logic [CFG_W-1:0]       count_reg;

    t_result                expected_results [$];

    bit                     sender_idle = 1'b1;
    bit                     sink_idle   = 1'b1;
    int                     hold_cycles = 0;
    int                     stall_left  = 0;

    int                     mismatches       = 0;
    int                     words_sent       = 0;
    int                     results_checked  = 0;
    int                     ticks_driven     = 0;
    int                     toggles_applied  = 0;
    int                     toggles_rejected = 0;
    int                     counts_written   = 0;
    int                     cycle_count      = 0;

    looping_pin_pattern_generator #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .PIN_COUNT   (PIN_COUNT)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // sample_index [15:0], pin_index [19:16], zero [23:20]
        .s_axis_tdata  (s_axis_tdata),
        // opcode [1:0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // pin_values [7:0], pins_driven [8], played_position [18:9], accepted [19],
        // zero [23:20]
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a run that hangs is a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The sample count as the block uses it, saturated to the store size.
    function automatic int live_samples();
        return (int'(count_reg) > MAX_SAMPLES) ? MAX_SAMPLES : int'(count_reg);
    endfunction

    // Works out the result of one accepted word and advances our copy of the state.
    function automatic t_result predict_word(input logic [OPCODE_W-1:0] op,
                                             input logic [SIDX_W-1:0]   sidx,
                                             input logic [PIDX_W-1:0]   pidx);
        t_result res;
        int      span;
        int      cur;
        res  = '0;
        span = live_samples();
        case (op)
            OP_TICK: begin
                res.accepted = 1'b1;
                if (span != 0) begin
                    // A position left beyond a shrunken count restarts at sample 0.
                    cur = (int'(play_pos) >= span) ? 0 : int'(play_pos);
                    res.pin_values      = pin_store[cur[POS_W-1:0]];
                    res.pins_driven     = 1'b1;
                    res.played_position = cur[POS_W-1:0];
                    play_pos = (cur + 1 >= span) ? '0 : POS_W'(cur + 1);
                    ticks_driven++;
                end
            end
            OP_TOGGLE: begin
                if (int'(sidx) < span && int'(pidx) < PIN_COUNT) begin
                    pin_store[sidx[POS_W-1:0]][pidx[PIN_IW-1:0]] =
                        ~pin_store[sidx[POS_W-1:0]][pidx[PIN_IW-1:0]];
                    res.accepted = 1'b1;
                    toggles_applied++;
                end else begin
                    toggles_rejected++;
                end
            end
            OP_RESTART: begin
                play_pos     = '0;
                res.accepted = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch on result word %0d: %s is 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    // Offers one word, with a random gap before it when the sender is idling.
    task automatic send_word(input logic [OPCODE_W-1:0] op,
                             input logic [SIDX_W-1:0]   sidx,
                             input logic [PIDX_W-1:0]   pidx);
        int gap;
        gap = 0;
        if (sender_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W - SIDX_W - PIDX_W){1'b0}}, pidx, sidx};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_word(op, sidx, pidx));
        words_sent++;
    endtask

    // Stops offering and waits until every result is back and the block is quiet.
    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        count_reg = value;
        counts_written++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly valid edits and ticks, with some restarts, rejected edits and unused opcodes.
    task automatic send_random_word();
        int                  roll;
        int                  span;
        logic [OPCODE_W-1:0] op;
        logic [SIDX_W-1:0]   sidx;
        logic [PIDX_W-1:0]   pidx;
        roll = $urandom_range(0, 99);
        span = live_samples();
        op   = OP_TOGGLE;
        sidx = SIDX_W'($urandom_range(0, 65535));
        pidx = PIDX_W'($urandom_range(0, 15));
        if (roll < 45) begin
            op = OP_TICK;
        end else if (roll < 80) begin
            sidx = (span > 0) ? SIDX_W'($urandom_range(0, span - 1)) : '0;
            pidx = PIDX_W'($urandom_range(0, PIN_COUNT - 1));
        end else if (roll < 86) begin
            op = OP_RESTART;
        end else if (roll < 90) begin
            // Just past the last sample of the loop.
            sidx = SIDX_W'(span);
            pidx = PIDX_W'($urandom_range(0, PIN_COUNT - 1));
        end else if (roll < 94) begin
            sidx = (span > 0) ? SIDX_W'($urandom_range(0, span - 1)) : '0;
            pidx = PIDX_W'($urandom_range(PIN_COUNT, 15));
        end else if (roll < 97) begin
            op = OP_UNUSED;
        end
        send_word(op, sidx, pidx);
    endtask

    // Right after reset the count is zero: nothing plays and no edit is taken.
    task automatic test_idle_after_reset();
        send_word(OP_TICK, 16'h0000, 4'h0);
        send_word(OP_TOGGLE, 16'h0000, 4'h0);
        send_word(OP_RESTART, 16'h0000, 4'h0);
        send_word(OP_UNUSED, 16'hFFFF, 4'hF);
        settle_block();
    endtask

    // Edits at the pin and sample limits, wrap-around, and a count shrunk
    // below the play position.
    task automatic test_edit_and_wrap();
        write_count(11'd4);
        send_word(OP_TOGGLE, 16'd3, 4'd7);
        send_word(OP_TOGGLE, 16'd0, 4'd0);
        send_word(OP_TOGGLE, 16'd4, 4'd0);
        send_word(OP_TOGGLE, 16'hFFFF, 4'hF);
        send_word(OP_TOGGLE, 16'd1, 4'd8);
        repeat (5) send_word(OP_TICK, 16'h0000, 4'h0);
        settle_block();
        // A zero count plays nothing and keeps the position.
        write_count(11'd0);
        send_word(OP_TICK, 16'h0000, 4'h0);
        settle_block();
        write_count(11'd1);
        send_word(OP_TICK, 16'h0000, 4'h0);
        send_word(OP_TICK, 16'h0000, 4'h0);
        settle_block();
    endtask

    // A count above the store size saturates to the store size.
    task automatic test_count_limits();
        write_count(11'd2047);
        send_word(OP_TOGGLE, 16'd1023, 4'd7);
        send_word(OP_TOGGLE, 16'd1024, 4'd1);
        send_word(OP_RESTART, 16'h0000, 4'h0);
        send_word(OP_TICK, 16'h0000, 4'h0);
        settle_block();
    endtask

    task automatic test_random_patterns();
        int phase_counts [10];
        int p;
        int n;
        phase_counts = '{1024, 2047, 1, 2, 1023, $urandom_range(3, 40),
                         $urandom_range(0, 2047), 0, $urandom_range(1, 64), 1024};
        for (p = 0; p < 10; p++) begin
            write_count(CFG_W'(phase_counts[p]));
            sender_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            for (n = 0; n < 65; n++) send_random_word();
            settle_block();
        end
        sender_idle = 1'b1;
        sink_idle   = 1'b1;
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_stall();
        int n;
        sender_idle = 1'b0;
        hold_cycles = 80;
        for (n = 0; n < 24; n++) send_random_word();
        settle_block();
        sender_idle = 1'b1;
    endtask

    // Back to back on both sides, at a short loop and at the full store.
    task automatic test_streaming();
        int n;
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        write_count(11'd3);
        for (n = 0; n < 40; n++) send_random_word();
        settle_block();
        write_count(11'd1024);
        for (n = 0; n < 60; n++) send_random_word();
        settle_block();
    endtask

    // Receiver: random stall bursts, or a long hold-off when one is asked for.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_idle && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // Each result word is compared field by field with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected", int'(m_axis_tdata), 0);
            end else begin
                want = expected_results.pop_front();
                if (got.pin_values !== want.pin_values)
                    report_mismatch("pin_values", int'(got.pin_values),
                                    int'(want.pin_values));
                if (got.pins_driven !== want.pins_driven)
                    report_mismatch("pins_driven", int'(got.pins_driven),
                                    int'(want.pins_driven));
                if (got.played_position !== want.played_position)
                    report_mismatch("played_position", int'(got.played_position),
                                    int'(want.played_position));
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
                if (m_axis_tdata[M_TDATA_W-1:RES_W] !== '0)
                    report_mismatch("padding", int'(m_axis_tdata[M_TDATA_W-1:RES_W]), 0);
            end
            results_checked++;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        for (int i = 0; i < MAX_SAMPLES; i++) pin_store[i] = '0;
        play_pos  = '0;
        count_reg = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_edit_and_wrap();
        test_count_limits();
        test_random_patterns();
        test_output_stall();
        test_streaming();
        settle_block();

        $display("Covered %0d words and %0d results over %0d sample count settings.",
                 words_sent, results_checked, counts_written);
        $display("Ticks that drove pins: %0d, edits applied: %0d, edits rejected: %0d.",
                 ticks_driven, toggles_applied, toggles_rejected);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lpg_pkg.sv
rtl/core/lpg_store.sv
rtl/core/looping_pin_pattern_generator.sv
verif/tb_top.sv
